FILE: hw/rtl/wia_pkg.sv
// ----------------------------------------------------------------------------
// wia_pkg: shared types and constants
// Operation codes and the request record passed between front and back ends.
// ----------------------------------------------------------------------------
package wia_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned NUM_W  = 256;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_SHL = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [NUM_W-1:0] a;
    logic [NUM_W-1:0] b;
    logic [7:0]       sh;
  } req_t;

endpackage

FILE: hw/rtl/wia_front.sv
// ----------------------------------------------------------------------------
// wia_front: request intake
// Registers accepted requests into a two-entry queue; busy when full.
// ----------------------------------------------------------------------------
module wia_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wia_pkg::req_t push_req,
  output logic          full,
  output logic          req_valid,
  output wia_pkg::req_t req,
  input  logic          pop
);
  wia_pkg::req_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;

  assign full      = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wr_r] <= push_req;
  end
endmodule

FILE: hw/rtl/wia_back.sv
// ----------------------------------------------------------------------------
// wia_back: execution unit
// Add/sub/neg/shift in one pass; multiply by 32x32 partial products, 36 steps.
// ----------------------------------------------------------------------------
module wia_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  wia_pkg::req_t req,
  output logic          pop,
  output logic          out_valid,
  output logic [255:0]  out_res
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_LAST} st_t;
  st_t           st_r;
  logic [255:0]  acc_r, a_r, b_r, res_r;
  logic [63:0]   prod_r;
  logic [2:0]    i_r, j_r, k_r;
  logic          vld_r;
  logic [255:0]  simple, add_x, add_y, sum, term, acc_sum;
  logic [31:0]   a_limb, b_limb;
  logic [63:0]   prod;
  logic          add_c;

  assign pop = req_valid && (st_r == S_IDLE);

  always_comb begin
    add_x = req.a;
    add_y = req.b;
    add_c = 1'b0;
    simple = '0;
    unique case (req.kind)
      wia_pkg::OP_SUB: begin add_y = ~req.b; add_c = 1'b1; end
      wia_pkg::OP_NEG: begin add_x = ~req.a; add_y = '0; add_c = 1'b1; end
      default: ;
    endcase
    sum = add_x + add_y + {255'd0, add_c};
    unique case (req.kind)
      wia_pkg::OP_ADD, wia_pkg::OP_SUB, wia_pkg::OP_NEG: simple = sum;
      wia_pkg::OP_SHL: simple = req.a << req.sh;
      default: simple = '0;
    endcase
  end

  // only limb pairs with i + j < 8 reach the low 256 bits
  assign a_limb  = a_r[{i_r, 5'd0} +: 32];
  assign b_limb  = b_r[{j_r, 5'd0} +: 32];
  assign prod    = {32'd0, a_limb} * {32'd0, b_limb};
  assign term    = {192'd0, prod_r} << {k_r, 5'd0};
  assign acc_sum = acc_r + term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      vld_r <= 1'b0;
    end else begin
      vld_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (pop) begin
            if (req.kind == wia_pkg::OP_MUL) begin
              a_r    <= req.a;
              b_r    <= req.b;
              acc_r  <= '0;
              prod_r <= '0;
              k_r    <= '0;
              i_r    <= '0;
              j_r    <= '0;
              st_r   <= S_MUL;
            end else begin
              res_r <= simple;
              vld_r <= 1'b1;
            end
          end
        end
        S_MUL: begin
          acc_r  <= acc_sum;
          prod_r <= prod;
          k_r    <= i_r + j_r;
          if (i_r + j_r == 3'd7) begin
            i_r <= i_r + 3'd1;
            j_r <= '0;
          end else begin
            j_r <= j_r + 3'd1;
          end
          if (i_r == 3'd7) st_r <= S_LAST;
        end
        S_LAST: begin
          res_r <= acc_sum;
          vld_r <= 1'b1;
          st_r  <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;
endmodule

FILE: hw/rtl/wide_integer_alu_256.sv
// ----------------------------------------------------------------------------
// wide_integer_alu_256: 256-bit integer ALU
// Add, subtract, negate, low-half multiply and left shift modulo 2^256.
// ----------------------------------------------------------------------------
// Requests pass the queue, then the result register. Throughput: one request
// per cycle for non-multiply while busy is low; multiply holds the execution
// unit for 36 32x32 partial-product steps plus issue and finish.
// Synchronous active-low reset empties the queue; the receiver cannot stall.
module wide_integer_alu_256 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_a_word0, in_a_word1, in_a_word2, in_a_word3,
  input  logic [63:0] in_b_word0, in_b_word1, in_b_word2, in_b_word3,
  input  logic [7:0]  in_shift_amount,
  output logic        out_valid,
  output logic [63:0] out_result_word0, out_result_word1,
  output logic [63:0] out_result_word2, out_result_word3
);
  wia_pkg::req_t push_req, req;
  logic          req_valid, pop;
  logic [255:0]  res;

  assign push_req.kind = in_kind;
  assign push_req.a    = {in_a_word3, in_a_word2, in_a_word1, in_a_word0};
  assign push_req.b    = {in_b_word3, in_b_word2, in_b_word1, in_b_word0};
  assign push_req.sh   = in_shift_amount;

  wia_front u_front (
    .clk, .rst_n, .push(start && !busy), .push_req, .full(busy),
    .req_valid, .req, .pop
  );

  wia_back u_back (
    .clk, .rst_n, .req_valid, .req, .pop, .out_valid(out_valid), .out_res(res)
  );

  assign out_result_word0 = res[63:0];
  assign out_result_word1 = res[127:64];
  assign out_result_word2 = res[191:128];
  assign out_result_word3 = res[255:192];
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: wide_integer_alu_256
// Drives directed and random 256-bit ALU requests through the start/busy
// handshake, predicts each result with a behavioral model at the block's
// widths, and compares every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_kind = '0;
  logic [63:0] in_a_word0 = '0, in_a_word1 = '0, in_a_word2 = '0, in_a_word3 = '0;
  logic [63:0] in_b_word0 = '0, in_b_word1 = '0, in_b_word2 = '0, in_b_word3 = '0;
  logic [7:0]  in_shift_amount = '0;
  logic        out_valid;
  logic [63:0] out_result_word0, out_result_word1, out_result_word2, out_result_word3;

  logic [255:0] pending_results[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           idle_enable = 1'b1;

  localparam int CYCLE_LIMIT = 400000;

  always #1 clk = ~clk;

  wide_integer_alu_256 dut (.*);

  function automatic logic [255:0] alu_result(logic [2:0] kind, logic [255:0] a,
                                              logic [255:0] b, logic [7:0] sh);
    logic [255:0] acc;
    acc = '0;
    case (kind)
      wia_pkg::OP_ADD: acc = a + b;
      wia_pkg::OP_SUB: acc = a + ~b + 256'd1;
      wia_pkg::OP_NEG: acc = ~a + 256'd1;
      wia_pkg::OP_MUL: begin
        for (int i = 0; i < 256; i++)
          if (a[i]) acc = acc + (b << i);
      end
      wia_pkg::OP_SHL: acc = a << sh;
      default: acc = '0;
    endcase
    return acc;
  endfunction

  task automatic send_request(logic [2:0] kind, logic [255:0] a, logic [255:0] b,
                              logic [7:0] sh);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    {in_a_word3, in_a_word2, in_a_word1, in_a_word0} <= a;
    {in_b_word3, in_b_word2, in_b_word1, in_b_word0} <= b;
    in_shift_amount <= sh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(alu_result(kind, a, b, sh));
    @(negedge clk);
  endtask

  function automatic logic [255:0] rand_wide();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(0, 255);
      3: v = 256'd1 << $urandom_range(0, 255);
      default: ;
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  always @(posedge clk) begin
    logic [255:0] got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      got = {out_result_word3, out_result_word2, out_result_word1, out_result_word0};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        for (int w = 0; w < 4; w++)
          if (got[w*64 +: 64] !== want[w*64 +: 64]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result_word%0d mismatch: expected %h actual %h", w,
                       want[w*64 +: 64], got[w*64 +: 64]);
          end
      end
    end
  end

  always @(posedge clk)
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end

  task automatic test_directed();
    logic [255:0] ones;
    ones = '1;
    send_request(wia_pkg::OP_ADD, ones, 256'd1, 8'd0);
    send_request(wia_pkg::OP_ADD, {192'd0, 64'hFFFF_FFFF_FFFF_FFFF}, {192'd0, 64'd1},
                 8'hFF);
    send_request(wia_pkg::OP_ADD, {4{64'hFFFF_FFFF_FFFF_FFFF}}, ones, 8'd0);
    send_request(wia_pkg::OP_SUB, '0, 256'd1, 8'd0);
    send_request(wia_pkg::OP_SUB, ones, ones, 8'd0);
    send_request(wia_pkg::OP_NEG, '0, ones, 8'd0);
    send_request(wia_pkg::OP_NEG, 256'd1, '0, 8'd0);
    send_request(wia_pkg::OP_MUL, ones, ones, 8'd0);
    send_request(wia_pkg::OP_MUL, '0, ones, 8'd0);
    send_request(wia_pkg::OP_MUL, {128'd0, {2{64'hFFFF_FFFF_FFFF_FFFF}}},
                 {128'd0, ones[127:0]}, 8'd0);
    send_request(wia_pkg::OP_SHL, ones, '0, 8'd0);
    send_request(wia_pkg::OP_SHL, ones, '0, 8'd255);
    send_request(wia_pkg::OP_SHL, 256'd1, ones, 8'd64);
    send_request(wia_pkg::OP_SHL, ones, '0, 8'd63);
    send_request(3'd5, ones, ones, 8'hFF);
    send_request(3'd6, ones, ones, 8'd0);
    send_request(3'd7, ones, ones, 8'd1);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++)
      send_request(3'($urandom_range(0, 7)), rand_wide(), rand_wide(),
                   8'($urandom_range(0, 255)));
  endtask

  task automatic test_back_to_back(int count);
    idle_enable = 1'b0;
    for (int n = 0; n < count; n++)
      send_request(3'($urandom_range(0, 4)), rand_wide(), rand_wide(),
                   8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_random(750);
    wait_drained();
    test_back_to_back(180);
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/wia_pkg.sv
hw/rtl/wia_front.sv
hw/rtl/wia_back.sv
hw/rtl/wide_integer_alu_256.sv
tb/sv/testbench.sv
